### hdl/gisi_pkg.sv
// Package of the GPIO set-up string interpreter.
// Holds the character codes, status and action codes and the command record.
// No dependencies; every other file but gisi_intf imports it.
package gisi_pkg;

    localparam int MAX_CMD_CHARS_DEF = 8;
    localparam int NUM_PORTS_DEF     = 5;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_PORT  = 2'd1;
    localparam logic [1:0] KIND_PAUSE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_LONG  = 3'd1;
    localparam logic [2:0] ST_BAD_PORT  = 3'd2;
    localparam logic [2:0] ST_BAD_PAUSE = 3'd3;
    localparam logic [2:0] ST_UNKNOWN   = 3'd4;
    localparam logic [2:0] ST_SKIPPED   = 3'd5;

    // Pin actions: data and direction both set, data cleared with output on,
    // both cleared, data set with input direction.
    localparam logic [1:0] ACT_OUT_HIGH = 2'd0;
    localparam logic [1:0] ACT_OUT_LOW  = 2'd1;
    localparam logic [1:0] ACT_IN_LOW   = 2'd2;
    localparam logic [1:0] ACT_IN_HIGH  = 2'd3;

    typedef struct packed {
        logic [1:0]  action_kind;
        logic [2:0]  status_code;
        logic [2:0]  port_index;
        logic [2:0]  pin;
        logic [1:0]  act;
        logic [15:0] pause_ms;
        logic [7:0]  char_position;
        logic        string_end;
    } gisi_cmd_t;

    typedef struct packed {
        logic [1:0]  action_kind;
        logic [2:0]  status_code;
        logic [2:0]  port_index;
        logic [7:0]  port_data_value;
        logic [7:0]  port_dir_value;
        logic [15:0] pause_ms;
        logic [7:0]  char_position;
        logic        string_end;
    } gisi_res_t;

endpackage

### hdl/gisi_intf.sv
// Channel interfaces of the GPIO set-up string interpreter.
// Character input channel and result output channel; no dependencies.
interface gisi_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       string_last;

    modport source (output valid, output char_code, output string_last, input ready);
    modport sink (input valid, input char_code, input string_last, output ready);
endinterface

interface gisi_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action_kind;
    logic [2:0]  status_code;
    logic [2:0]  port_index;
    logic [7:0]  port_data_value;
    logic [7:0]  port_dir_value;
    logic [15:0] pause_ms;
    logic [7:0]  char_position;
    logic        string_end;

    modport source (output valid, output action_kind, output status_code,
                    output port_index, output port_data_value, output port_dir_value,
                    output pause_ms, output char_position, output string_end,
                    input ready);
    modport sink (input valid, input action_kind, input status_code,
                  input port_index, input port_data_value, input port_dir_value,
                  input pause_ms, input char_position, input string_end,
                  output ready);
endinterface

### hdl/gpio_init_string_interpreter_unit.sv
// Top level of the GPIO set-up string interpreter.
// Depends on gisi_pkg, gisi_intf, gisi_front, gisi_queue and gisi_back.
//
// Channel   Direction  Payload
// chars     in         char_code[7:0], string_last
// results   out        action_kind, status_code, port_index, port_data_value,
//                      port_dir_value, pause_ms, char_position, string_end
// cfg       in         cfg_we, cfg_wdata (validate_only)
//
// One character is accepted per cycle while the queue has room; the front end
// checks it in that cycle. A result turns valid after passing through the queue
// and then the output register. The queue holds two commands; input stalls only
// once both entries are full behind a result that waits at the output.
// Reset clears the port registers, the command state and the queue at once.
module gpio_init_string_interpreter_unit
    import gisi_pkg::*;
#(
    parameter int MAX_CMD_CHARS = MAX_CMD_CHARS_DEF,
    parameter int NUM_PORTS     = NUM_PORTS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_wdata,
    gisi_char_if.sink     chars,
    gisi_result_if.source results
);

    logic      validate_only_reg;
    logic      validate_only_next;
    logic      push;
    logic      pop;
    logic      not_full;
    logic      not_empty;
    gisi_cmd_t push_cmd;
    gisi_cmd_t pop_cmd;

    assign validate_only_next = cfg_we ? cfg_wdata : validate_only_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            validate_only_reg <= 1'b0;
        end
        else
        begin
            validate_only_reg <= validate_only_next;
        end
    end

    gisi_front #(
        .MAX_CMD_CHARS (MAX_CMD_CHARS),
        .NUM_PORTS     (NUM_PORTS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .validate_only (validate_only_reg),
        .chars         (chars),
        .queue_ready   (not_full),
        .push          (push),
        .cmd           (push_cmd)
    );

    gisi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .not_full  (not_full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_data  (pop_cmd)
    );

    gisi_back #(
        .NUM_PORTS (NUM_PORTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (not_empty),
        .cmd       (pop_cmd),
        .pop       (pop),
        .results   (results)
    );

endmodule

### hdl/gisi_front.sv
// Front end: accepts characters, gathers the command and checks it on the fly.
// Depends on gisi_pkg and gisi_char_if; emits command records to the queue.
module gisi_front
    import gisi_pkg::*;
#(
    parameter int MAX_CMD_CHARS = MAX_CMD_CHARS_DEF,
    parameter int NUM_PORTS     = NUM_PORTS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             validate_only,
    gisi_char_if.sink        chars,
    input  logic             queue_ready,
    output logic             push,
    output gisi_cmd_t        cmd
);

    localparam int LEN_W = $clog2(MAX_CMD_CHARS + 1);

    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       first_reg, first_next;
    logic [7:0]       pin_reg, pin_next;
    logic [7:0]       act_reg, act_next;
    logic [15:0]      pause_reg, pause_next;
    logic [7:0]       pos_reg, pos_next;
    logic             aborted_reg, aborted_next;
    logic             accept;
    logic             is_comma;
    logic             ends;
    logic             err;
    logic [7:0]       port_num;
    logic             act_valid;
    logic [1:0]       act_code;
    logic [2:0]       status;

    assign chars.ready = queue_ready;
    assign accept      = chars.valid && queue_ready;
    assign is_comma    = (chars.char_code == CH_COMMA);
    assign ends        = is_comma || chars.string_last;
    assign port_num    = first_next - CH_B;

    always_comb
    begin
        act_valid = 1'b1;
        act_code  = ACT_OUT_HIGH;
        priority if (act_next == CH_PLUS)
        begin
            act_code = ACT_OUT_HIGH;
        end
        else if (act_next == CH_MINUS)
        begin
            act_code = ACT_OUT_LOW;
        end
        else if (act_next == CH_TILDE)
        begin
            act_code = ACT_IN_LOW;
        end
        else if (act_next == CH_CARET)
        begin
            act_code = ACT_IN_HIGH;
        end
        else
        begin
            act_valid = 1'b0;
        end
    end

    always_comb
    begin
        len_next     = len_reg;
        first_next   = first_reg;
        pin_next     = pin_reg;
        act_next     = act_reg;
        pause_next   = pause_reg;
        pos_next     = pos_reg;
        aborted_next = aborted_reg;
        push         = 1'b0;
        err          = 1'b0;
        status       = ST_OK;
        cmd          = '0;
        cmd.char_position = pos_reg;
        cmd.string_end    = chars.string_last;
        if (accept)
        begin
            pos_next = pos_reg + 8'd1;
            if (aborted_reg)
            begin
                push            = 1'b1;
                cmd.status_code = ST_SKIPPED;
            end
            else
            begin
                if (!is_comma)
                begin
                    if (len_reg >= LEN_W'(MAX_CMD_CHARS))
                    begin
                        push            = 1'b1;
                        cmd.status_code = ST_TOO_LONG;
                        err             = 1'b1;
                    end
                    else
                    begin
                        if (len_reg == '0)
                        begin
                            first_next = chars.char_code;
                            pause_next = '0;
                        end
                        else
                        begin
                            pause_next = {pause_reg[12:0], 3'b000} + {pause_reg[14:0], 1'b0}
                                         + {8'd0, chars.char_code} - {8'd0, CH_ZERO};
                        end
                        if (len_reg == LEN_W'(1))
                        begin
                            pin_next = chars.char_code;
                        end
                        if (len_reg == LEN_W'(2))
                        begin
                            act_next = chars.char_code;
                        end
                        len_next = len_reg + LEN_W'(1);
                    end
                end
                if (!err && ends)
                begin
                    push = 1'b1;
                    priority if (len_next == '0)
                    begin
                        status = ST_UNKNOWN;
                    end
                    else if (first_next == CH_P)
                    begin
                        if (len_next < LEN_W'(2))
                        begin
                            status = ST_BAD_PAUSE;
                        end
                        else if (!validate_only)
                        begin
                            cmd.action_kind = KIND_PAUSE;
                            cmd.pause_ms    = pause_next;
                        end
                    end
                    else if (first_next >= CH_B && first_next <= CH_F)
                    begin
                        if (len_next != LEN_W'(3) || port_num >= 8'(NUM_PORTS)
                            || pin_next < CH_ZERO || pin_next > CH_SEVEN || !act_valid)
                        begin
                            status = ST_BAD_PORT;
                        end
                        else if (!validate_only)
                        begin
                            cmd.action_kind = KIND_PORT;
                            cmd.port_index  = port_num[2:0];
                            cmd.pin         = pin_next[2:0];
                            cmd.act         = act_code;
                        end
                    end
                    else
                    begin
                        status = ST_UNKNOWN;
                    end
                    cmd.status_code = status;
                    err             = (status != ST_OK);
                    len_next        = '0;
                end
                if (err)
                begin
                    aborted_next = 1'b1;
                end
            end
            if (chars.string_last)
            begin
                len_next     = '0;
                pos_next     = '0;
                aborted_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            pos_reg     <= '0;
            aborted_reg <= 1'b0;
        end
        else
        begin
            len_reg     <= len_next;
            pos_reg     <= pos_next;
            aborted_reg <= aborted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        pin_reg   <= pin_next;
        act_reg   <= act_next;
        pause_reg <= pause_next;
    end

    a_error_aborts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && cmd.status_code != ST_OK && cmd.status_code != ST_SKIPPED
         && !cmd.string_end) |=> aborted_reg)
        else $error("Error status did not abort the string.");

endmodule

### hdl/gisi_queue.sv
// Short command queue between the front end and the back end.
// Depends on gisi_pkg for the command record and the depth.
module gisi_queue
    import gisi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  gisi_cmd_t push_data,
    output logic      not_full,
    input  logic      pop,
    output logic      not_empty,
    output gisi_cmd_t pop_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    gisi_cmd_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_full  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (not_full || pop))
        else $error("Queue written while full.");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("Queue count lost a write.");

endmodule

### hdl/gisi_back.sv
// Back end: carries out port updates on the port registers and holds the result.
// Depends on gisi_pkg and gisi_result_if; reads command records from the queue.
module gisi_back
    import gisi_pkg::*;
#(
    parameter int NUM_PORTS = NUM_PORTS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cmd_valid,
    input  gisi_cmd_t    cmd,
    output logic         pop,
    gisi_result_if.source results
);

    localparam int PIDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    logic [7:0]        data_reg [NUM_PORTS];
    logic [7:0]        dir_reg [NUM_PORTS];
    logic              out_valid_reg, out_valid_next;
    gisi_res_t         res_reg, res_next;
    logic [PIDX_W-1:0] pidx;
    logic [7:0]        mask;
    logic [7:0]        new_data;
    logic [7:0]        new_dir;
    logic              is_port;

    assign pop     = cmd_valid && (!out_valid_reg || results.ready);
    assign pidx    = cmd.port_index[PIDX_W-1:0];
    assign mask    = 8'd1 << cmd.pin;
    assign is_port = (cmd.action_kind == KIND_PORT);

    always_comb
    begin
        new_data = data_reg[pidx];
        new_dir  = dir_reg[pidx];
        unique case (cmd.act)
            ACT_OUT_HIGH:
            begin
                new_data = new_data | mask;
                new_dir  = new_dir | mask;
            end
            ACT_OUT_LOW:
            begin
                new_data = new_data & ~mask;
                new_dir  = new_dir | mask;
            end
            ACT_IN_LOW:
            begin
                new_data = new_data & ~mask;
                new_dir  = new_dir & ~mask;
            end
            ACT_IN_HIGH:
            begin
                new_data = new_data | mask;
                new_dir  = new_dir & ~mask;
            end
            default:
            begin
                new_data = data_reg[pidx];
                new_dir  = dir_reg[pidx];
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            out_valid_next           = 1'b1;
            res_next.action_kind     = cmd.action_kind;
            res_next.status_code     = cmd.status_code;
            res_next.port_index      = cmd.port_index;
            res_next.port_data_value = is_port ? new_data : 8'd0;
            res_next.port_dir_value  = is_port ? new_dir : 8'd0;
            res_next.pause_ms        = cmd.pause_ms;
            res_next.char_position   = cmd.char_position;
            res_next.string_end      = cmd.string_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                data_reg[p] <= 8'd0;
                dir_reg[p]  <= 8'd0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                if (pop && is_port && pidx == PIDX_W'(p))
                begin
                    data_reg[p] <= new_data;
                    dir_reg[p]  <= new_dir;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign results.valid           = out_valid_reg;
    assign results.action_kind     = res_reg.action_kind;
    assign results.status_code     = res_reg.status_code;
    assign results.port_index      = res_reg.port_index;
    assign results.port_data_value = res_reg.port_data_value;
    assign results.port_dir_value  = res_reg.port_dir_value;
    assign results.pause_ms        = res_reg.pause_ms;
    assign results.char_position   = res_reg.char_position;
    assign results.string_end      = res_reg.string_end;

    a_action_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.action_kind != KIND_NONE) |-> (res_reg.status_code == ST_OK))
        else $error("Action issued with an error status.");

endmodule

### dv/tb_top.sv
// Testbench for the GPIO set-up string interpreter; checks every result field by field
// against a cycle-free predictor of the string parser, under random idling and back-pressure.
// Depends on gisi_pkg, gisi_intf and gpio_init_string_interpreter_unit.
module tb_top;
    import gisi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_CHARS   = 1850;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    gisi_char_if   char_ch();
    gisi_result_if result_ch();

    gpio_init_string_interpreter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .chars     (char_ch),
        .results   (result_ch)
    );

    // Predictor state.
    logic [7:0] port_data [NUM_PORTS_DEF];
    logic [7:0] port_dir [NUM_PORTS_DEF];
    logic [7:0] cmd_buf [MAX_CMD_CHARS_DEF];
    int         cmd_len;
    logic [7:0] char_pos;
    bit         aborted;
    bit         validate_mode;

    gisi_res_t expected_results[$];

    int  error_count;
    int  chars_sent;
    int  results_seen;
    int  status_seen [8];
    int  stall_cycles;
    int  quiet_cycles;
    bit  chars_steady;
    bit  results_steady;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic run_command(inout gisi_res_t r);
        logic [7:0]  first;
        logic [7:0]  pin;
        logic [7:0]  act;
        logic [7:0]  mask;
        logic [15:0] pause;
        int          port;
        first = cmd_buf[0];
        if (cmd_len == 0) begin
            r.status_code = ST_UNKNOWN;
        end
        else if (first == CH_P) begin
            if (cmd_len < 2) begin
                r.status_code = ST_BAD_PAUSE;
            end
            else begin
                pause = '0;
                for (int i = 1; i < cmd_len; i++)
                begin
                    pause = pause * 16'd10 + {8'h00, cmd_buf[i]} - {8'h00, CH_ZERO};
                end
                r.status_code = ST_OK;
                if (!validate_mode)
                begin
                    r.action_kind = KIND_PAUSE;
                    r.pause_ms = pause;
                end
            end
        end
        else if (first >= CH_B && first <= CH_F) begin
            port = first - CH_B;
            pin = cmd_buf[1];
            act = cmd_buf[2];
            if (cmd_len != 3 || port >= NUM_PORTS_DEF || pin < CH_ZERO || pin > CH_SEVEN ||
                !(act == CH_PLUS || act == CH_MINUS || act == CH_TILDE || act == CH_CARET))
            begin
                r.status_code = ST_BAD_PORT;
            end
            else begin
                r.status_code = ST_OK;
                if (!validate_mode)
                begin
                    mask = 8'd1 << (pin - CH_ZERO);
                    if (act == CH_PLUS || act == CH_CARET)
                        port_data[port] = port_data[port] | mask;
                    else
                        port_data[port] = port_data[port] & ~mask;
                    if (act == CH_PLUS || act == CH_MINUS)
                        port_dir[port] = port_dir[port] | mask;
                    else
                        port_dir[port] = port_dir[port] & ~mask;
                    r.action_kind = KIND_PORT;
                    r.port_index = port[2:0];
                    r.port_data_value = port_data[port];
                    r.port_dir_value = port_dir[port];
                end
            end
        end
        else begin
            r.status_code = ST_UNKNOWN;
        end
    endtask

    task automatic interpret_char(input logic [7:0] c, input bit last);
        gisi_res_t r;
        bit        has_result;
        bit        failed;
        r = '0;
        r.char_position = char_pos;
        r.string_end = last;
        has_result = 1'b0;
        failed = 1'b0;
        if (aborted) begin
            r.status_code = ST_SKIPPED;
            has_result = 1'b1;
        end
        else begin
            if (c != CH_COMMA)
            begin
                if (cmd_len >= MAX_CMD_CHARS_DEF) begin
                    r.status_code = ST_TOO_LONG;
                    has_result = 1'b1;
                    failed = 1'b1;
                end
                else begin
                    cmd_buf[cmd_len] = c;
                    cmd_len++;
                end
            end
            if (!failed && (c == CH_COMMA || last))
            begin
                run_command(r);
                has_result = 1'b1;
                failed = (r.status_code != ST_OK);
                cmd_len = 0;
            end
            if (failed)
                aborted = 1'b1;
        end
        char_pos = char_pos + 8'd1;
        if (last)
        begin
            cmd_len = 0;
            char_pos = '0;
            aborted = 1'b0;
        end
        if (has_result)
            expected_results.push_back(r);
    endtask

    task automatic send_item(input logic [7:0] c, input bit last);
        @(negedge clk);
        while (!chars_steady && $urandom_range(99) < 23)
        begin
            char_ch.valid <= 1'b0;
            @(negedge clk);
        end
        char_ch.valid <= 1'b1;
        char_ch.char_code <= c;
        char_ch.string_last <= last;
        @(posedge clk);
        while (!char_ch.ready)
            @(posedge clk);
        interpret_char(c, last);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], i == s.len() - 1);
    endtask

    task automatic send_bytes(input logic [7:0] text[$]);
        for (int i = 0; i < text.size(); i++)
            send_item(text[i], i == text.size() - 1);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        char_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_validate(input bit value);
        wait_drained();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        validate_mode = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic append_command(ref logic [7:0] text[$]);
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 55) begin
            if ($urandom_range(99) < 5)
                text.push_back(8'($urandom_range(8'h41, 8'h47)));
            else
                text.push_back(CH_B + 8'($urandom_range(0, 4)));
            if ($urandom_range(99) < 6)
                text.push_back(8'($urandom_range(0, 255)));
            else
                text.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
            if ($urandom_range(99) < 4)
                return;
            case ($urandom_range(0, 4))
                0: text.push_back(CH_PLUS);
                1: text.push_back(CH_MINUS);
                2: text.push_back(CH_TILDE);
                3: text.push_back(CH_CARET);
                default: text.push_back(($urandom_range(99) < 60) ?
                                        CH_PLUS : 8'($urandom_range(0, 255)));
            endcase
            if ($urandom_range(99) < 4)
                text.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind < 80) begin
            text.push_back(CH_P);
            n = ($urandom_range(99) < 8) ? $urandom_range(7, 10) : $urandom_range(0, 6);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(99) < 4)
                    text.push_back(8'($urandom_range(0, 255)));
                else
                    text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
        end
        else begin
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++)
                text.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_random_string(input int commands);
        logic [7:0] text[$];
        for (int i = 0; i < commands; i++)
        begin
            if (i != 0)
                text.push_back(CH_COMMA);
            append_command(text);
        end
        if (text.size() == 0 || $urandom_range(99) < 10)
            text.push_back(CH_COMMA);
        send_bytes(text);
    endtask

    task automatic send_port_string(input int commands);
        logic [7:0] text[$];
        for (int i = 0; i < commands; i++)
        begin
            text.push_back(CH_B + 8'($urandom_range(0, 4)));
            text.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
            case ($urandom_range(0, 3))
                0: text.push_back(CH_PLUS);
                1: text.push_back(CH_MINUS);
                2: text.push_back(CH_TILDE);
                default: text.push_back(CH_CARET);
            endcase
            if (i != commands - 1)
                text.push_back(CH_COMMA);
        end
        send_bytes(text);
    endtask

    task automatic test_port_actions();
        send_text("B0+,C7-,D3~,E5^,F7+,F7^");
    endtask

    task automatic test_pause_commands();
        send_text("P0,P65535,P65536,P1a");
        send_text("P");
        send_text("P,B0+");
    endtask

    task automatic test_error_cases();
        send_text("B8+");
        send_text("B0*,C1+");
        send_text("B0+1");
        send_text("G0+");
        send_text(",B0+");
        send_text("B0+,,C1+");
        send_text("P12345678");
        send_text("B0+123456789,C0+");
    endtask

    task automatic test_validate_mode();
        set_validate(1'b1);
        send_text("B1+,P77,C9+");
        send_text("P");
        set_validate(1'b0);
        send_text("B1-");
    endtask

    task automatic test_back_pressure();
        wait_drained();
        chars_steady = 1'b1;
        stall_cycles = 150;
        send_port_string(12);
        chars_steady = 1'b0;
    endtask

    task automatic test_long_string();
        chars_steady = 1'b1;
        results_steady = 1'b1;
        send_port_string(75);
        chars_steady = 1'b0;
        results_steady = 1'b0;
    endtask

    task automatic test_random_strings();
        while (chars_sent < RANDOM_CHARS)
        begin
            if ($urandom_range(99) < 8)
                set_validate(1'($urandom_range(0, 1)));
            send_random_string($urandom_range(1, 6));
        end
        set_validate(1'b0);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        char_ch.valid = 1'b0;
        char_ch.char_code = '0;
        char_ch.string_last = 1'b0;
        result_ch.ready = 1'b0;
        for (int i = 0; i < NUM_PORTS_DEF; i++)
        begin
            port_data[i] = '0;
            port_dir[i] = '0;
        end
        cmd_len = 0;
        char_pos = '0;
        aborted = 1'b0;
        validate_mode = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_port_actions();
        test_pause_commands();
        test_error_cases();
        test_validate_mode();
        test_back_pressure();
        test_long_string();
        test_random_strings();

        wait_drained();
        if (expected_results.size() != 0)
        begin
            $display("MISMATCH: %0d expected results never arrived", expected_results.size());
            error_count++;
        end
        $display("Sent %0d characters and checked %0d results: ok %0d, too long %0d,",
                 chars_sent, results_seen, status_seen[ST_OK], status_seen[ST_TOO_LONG]);
        $display("bad port %0d, bad pause %0d, unknown %0d, skipped %0d.",
                 status_seen[ST_BAD_PORT], status_seen[ST_BAD_PAUSE],
                 status_seen[ST_UNKNOWN], status_seen[ST_SKIPPED]);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(negedge clk)
    begin
        if (stall_cycles > 0) begin
            result_ch.ready <= 1'b0;
            stall_cycles <= stall_cycles - 1;
        end
        else if (results_steady) begin
            result_ch.ready <= 1'b1;
        end
        else begin
            result_ch.ready <= ($urandom_range(99) >= 23);
        end
    end

    always @(posedge clk)
    begin
        gisi_res_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("MISMATCH at %0t: result with no request waiting", $realtime);
                error_count++;
            end
            else begin
                want = expected_results.pop_front();
                status_seen[want.status_code]++;
                if (result_ch.action_kind !== want.action_kind)
                    report_mismatch("action_kind", 16'(result_ch.action_kind),
                                    16'(want.action_kind));
                if (result_ch.status_code !== want.status_code)
                    report_mismatch("status_code", 16'(result_ch.status_code),
                                    16'(want.status_code));
                if (result_ch.port_index !== want.port_index)
                    report_mismatch("port_index", 16'(result_ch.port_index),
                                    16'(want.port_index));
                if (result_ch.port_data_value !== want.port_data_value)
                    report_mismatch("port_data_value", 16'(result_ch.port_data_value),
                                    16'(want.port_data_value));
                if (result_ch.port_dir_value !== want.port_dir_value)
                    report_mismatch("port_dir_value", 16'(result_ch.port_dir_value),
                                    16'(want.port_dir_value));
                if (result_ch.pause_ms !== want.pause_ms)
                    report_mismatch("pause_ms", result_ch.pause_ms, want.pause_ms);
                if (result_ch.char_position !== want.char_position)
                    report_mismatch("char_position", 16'(result_ch.char_position),
                                    16'(want.char_position));
                if (result_ch.string_end !== want.string_end)
                    report_mismatch("string_end", 16'(result_ch.string_end),
                                    16'(want.string_end));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((char_ch.valid && char_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no request accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
